FILE: hdl/slrg_pkg.sv
// Shared types and constants for the stepped linear ramp generator.
// Used by slrg_muldiv and stepped_linear_ramp_generator_top.
package slrg_pkg;

	localparam int ACC_W  = 48;
	localparam int RATE_W = 18;
	localparam int TIME_W = 16;
	localparam int DIV_W  = 8;
	localparam int MULT_W = 18;
	localparam int DEN_W  = TIME_W + RATE_W;

	localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;
	localparam logic [MULT_W-1:0] MS_SCALE   = 18'd1000;
	localparam logic signed [ACC_W-1:0] INC_CAP = 48'sh7FFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_TICK  = 2'd1,
		OP_SNAP  = 2'd2
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PREP = 5'b00010,
		S_CALC = 5'b00100,
		S_TLVL = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_MUL  = 3'b010,
		MD_DIV  = 3'b100
	} md_phase_t;

endpackage

FILE: hdl/slrg_muldiv.sv
// Iterative shift-add multiplier and restoring divider on one shared adder.
// Computes min(floor(mag * divider * 1000 * 2^16 / (time_ms * rate)), cap).
// Depends on slrg_pkg.
module slrg_muldiv #(
	parameter int LW = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [LW:0]                   mag,
	input  logic [slrg_pkg::DIV_W-1:0]    tick_divider,
	input  logic [slrg_pkg::TIME_W-1:0]   ramp_time_ms,
	input  logic [slrg_pkg::RATE_W-1:0]   control_rate,
	output logic                          done,
	output logic [slrg_pkg::ACC_W-1:0]    quotient
);

	localparam int MW = LW + 1 + slrg_pkg::MULT_W;
	localparam int NW = MW + 16;
	localparam int CW = $clog2(NW + 1);
	localparam int DW = slrg_pkg::DEN_W;
	localparam int AW = slrg_pkg::ACC_W;

	slrg_pkg::md_phase_t phase_q;
	logic [CW-1:0]                  cnt_q;
	logic [MW-1:0]                  acc_q;
	logic [LW:0]                    mag_q;
	logic [slrg_pkg::MULT_W-1:0]    m_q;
	logic [DW-1:0]                  den_q;
	logic [DW-1:0]                  rem_q;
	logic [AW-1:0]                  q_q;
	logic                           ovf_q;
	logic                           zero_q;
	logic                           done_q;

	logic [MW-1:0] opa;
	logic [MW-1:0] opb;
	logic          cin;
	logic [MW:0]   sum;
	logic [DW:0]   r_sh;
	logic          ge;

	assign r_sh = {rem_q, acc_q[MW-1]};

	always_comb begin
		opa = {acc_q[MW-2:0], 1'b0};
		opb = '0;
		cin = 1'b0;
		if (phase_q == slrg_pkg::MD_MUL) begin
			opb = m_q[slrg_pkg::MULT_W-1] ? MW'(mag_q) : '0;
		end else begin
			opa = MW'(r_sh);
			opb = ~MW'(den_q);
			cin = 1'b1;
		end
	end

	assign sum = {1'b0, opa} + {1'b0, opb} + (MW + 1)'(cin);
	assign ge  = sum[MW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slrg_pkg::MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == slrg_pkg::MD_DIV) && (cnt_q == '0);
			case (phase_q)
				slrg_pkg::MD_IDLE: begin
					if (start) begin
						phase_q <= slrg_pkg::MD_MUL;
						cnt_q   <= CW'(slrg_pkg::MULT_W - 1);
					end
				end
				slrg_pkg::MD_MUL: begin
					if (cnt_q == '0) begin
						phase_q <= slrg_pkg::MD_DIV;
						cnt_q   <= CW'(NW - 1);
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				slrg_pkg::MD_DIV: begin
					if (cnt_q == '0) begin
						phase_q <= slrg_pkg::MD_IDLE;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: begin
					phase_q <= slrg_pkg::MD_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			slrg_pkg::MD_IDLE: begin
				if (start) begin
					mag_q  <= mag;
					m_q    <= slrg_pkg::MULT_W'(tick_divider) * slrg_pkg::MS_SCALE;
					den_q  <= DW'(ramp_time_ms) * DW'(control_rate);
					zero_q <= (mag == '0) || (tick_divider == '0);
					acc_q  <= '0;
				end
			end
			slrg_pkg::MD_MUL: begin
				acc_q <= sum[MW-1:0];
				m_q   <= {m_q[slrg_pkg::MULT_W-2:0], 1'b0};
				if (cnt_q == '0) begin
					rem_q <= '0;
					q_q   <= '0;
					ovf_q <= 1'b0;
				end
			end
			slrg_pkg::MD_DIV: begin
				acc_q <= {acc_q[MW-2:0], 1'b0};
				rem_q <= ge ? sum[DW-1:0] : r_sh[DW-1:0];
				q_q   <= {q_q[AW-2:0], ge};
				ovf_q <= ovf_q | q_q[AW-1];
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;

	always_comb begin
		if (zero_q) begin
			quotient = '0;
		end else if (ovf_q || q_q[AW-1]) begin
			quotient = slrg_pkg::INC_CAP;
		end else begin
			quotient = q_q;
		end
	end

endmodule

FILE: hdl/stepped_linear_ramp_generator_top.sv
// Top level of the stepped linear ramp generator: sequencer, ramp state, output register.
// Depends on slrg_pkg and slrg_muldiv.
//
// Usage:
//   Input channel in_valid / in_stall carries operation, target_level, ramp_time_ms and
//   tick_divider. Output channel out_valid / out_stall carries level and flag, one
//   result item for every input item, in order.
//   cfg_wr_en / cfg_wr_data write control_rate; write it only while the block is idle.
//   A start item whose target differs from the stored one runs the increment through
//   the shared shift-add/subtract unit: 18 multiply steps, then LEVEL_WIDTH + 35
//   divide steps. A tick item that advances the ramp goes through S_TLVL to S_FIN;
//   all other items except that start go from idle straight to S_FIN.
//   One item is worked on at a time; in_stall is high from acceptance until the
//   result has been moved into the output register.
//   The output register holds a finished item while out_stall is high; the next
//   input item is accepted and processed meanwhile and waits for the register.
//   Reset clears the level, target and ramp state, sets control_rate to 48000 and
//   leaves both channels empty.
module stepped_linear_ramp_generator_top #(
	parameter int LEVEL_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [slrg_pkg::RATE_W-1:0]       cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        operation,
	input  logic signed [31:0]                target_level,
	input  logic [slrg_pkg::TIME_W-1:0]       ramp_time_ms,
	input  logic [slrg_pkg::DIV_W-1:0]        tick_divider,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [31:0]                level,
	output logic                              flag
);

	localparam int LW = LEVEL_WIDTH;
	localparam int TW = (LW > 32) ? LW : 32;
	localparam int AW = slrg_pkg::ACC_W;
	localparam logic signed [TW-1:0] LMAX = TW'((64'sd1 <<< (LW - 1)) - 64'sd1);
	localparam logic signed [TW-1:0] LMIN = TW'(-(64'sd1 <<< (LW - 1)));
	localparam logic signed [TW-1:0] OMAX = TW'(64'sd2147483647);
	localparam logic signed [TW-1:0] OMIN = TW'(-64'sd2147483648);
	localparam logic signed [AW:0]   AMAX = (AW + 1)'(slrg_pkg::INC_CAP);
	localparam logic signed [AW:0]   AMIN = ~AMAX;

	slrg_pkg::state_t state_q;
	logic signed [LW-1:0]          cur_q;
	logic signed [LW-1:0]          goal_q;
	logic signed [LW-1:0]          origin_q;
	logic signed [AW-1:0]          inc_q;
	logic signed [AW-1:0]          acc_q;
	logic                          active_q;
	logic [slrg_pkg::DIV_W-1:0]    div_q;
	logic [slrg_pkg::DIV_W-1:0]    tick_q;
	logic [slrg_pkg::RATE_W-1:0]   rate_q;
	logic [slrg_pkg::TIME_W-1:0]   time_q;
	logic signed [LW:0]            diff_q;
	logic                          flag_q;
	logic                          out_valid_q;
	logic signed [31:0]            level_q;
	logic                          out_flag_q;

	logic                          in_acc;
	logic signed [TW-1:0]          t_ext;
	logic signed [LW-1:0]          tgt;
	logic signed [LW:0]            diff_d;
	logic [LW:0]                   mag;
	logic                          md_start;
	logic                          md_done;
	logic [AW-1:0]                 md_q;
	logic signed [AW-1:0]          inc_d;
	logic [slrg_pkg::DIV_W-1:0]    tick_nx;
	logic signed [AW:0]            acc_sum;
	logic signed [AW-1:0]          acc_d;
	logic signed [31:0]            off;
	logic signed [TW:0]            lsum;
	logic signed [LW-1:0]          lvl;
	logic                          going;
	logic signed [TW-1:0]          c_ext;
	logic signed [31:0]            lvl_out;
	logic                          out_free;

	assign in_stall = (state_q != slrg_pkg::S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign t_ext = TW'(target_level);
	always_comb begin
		if (t_ext > LMAX) begin
			tgt = LMAX[LW-1:0];
		end else if (t_ext < LMIN) begin
			tgt = LMIN[LW-1:0];
		end else begin
			tgt = t_ext[LW-1:0];
		end
	end

	assign diff_d   = (LW + 1)'(tgt) - (LW + 1)'(cur_q);
	assign mag      = diff_q[LW] ? (LW + 1)'(-diff_q) : diff_q;
	assign md_start = (state_q == slrg_pkg::S_PREP);

	slrg_muldiv #(
		.LW(LW)
	) u_muldiv (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (md_start),
		.mag          (mag),
		.tick_divider (div_q),
		.ramp_time_ms (time_q),
		.control_rate (rate_q),
		.done         (md_done),
		.quotient     (md_q)
	);

	always_comb begin
		if (md_q == '0) begin
			if (diff_q == '0) begin
				inc_d = '0;
			end else if (diff_q[LW]) begin
				inc_d = -48'sd1;
			end else begin
				inc_d = 48'sd1;
			end
		end else if (diff_q[LW]) begin
			inc_d = -$signed(md_q);
		end else begin
			inc_d = $signed(md_q);
		end
	end

	assign tick_nx = tick_q + slrg_pkg::DIV_W'(1);
	assign acc_sum = (AW + 1)'(inc_q) + (AW + 1)'(acc_q);
	always_comb begin
		if (acc_sum > AMAX) begin
			acc_d = AMAX[AW-1:0];
		end else if (acc_sum < AMIN) begin
			acc_d = AMIN[AW-1:0];
		end else begin
			acc_d = acc_sum[AW-1:0];
		end
	end

	assign off  = acc_q[AW-1:16];
	assign lsum = (TW + 1)'(origin_q) + (TW + 1)'(off);
	always_comb begin
		if (lsum > (TW + 1)'(LMAX)) begin
			lvl = LMAX[LW-1:0];
		end else if (lsum < (TW + 1)'(LMIN)) begin
			lvl = LMIN[LW-1:0];
		end else begin
			lvl = lsum[LW-1:0];
		end
		if (inc_q[AW-1] || (inc_q == '0)) begin
			going = lvl > goal_q;
		end else begin
			going = lvl < goal_q;
		end
	end

	assign c_ext = TW'(cur_q);
	always_comb begin
		if (c_ext > OMAX) begin
			lvl_out = OMAX[31:0];
		end else if (c_ext < OMIN) begin
			lvl_out = OMIN[31:0];
		end else begin
			lvl_out = c_ext[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slrg_pkg::S_IDLE;
			cur_q       <= '0;
			goal_q      <= '0;
			origin_q    <= '0;
			inc_q       <= '0;
			acc_q       <= '0;
			active_q    <= 1'b0;
			div_q       <= '0;
			tick_q      <= '0;
			rate_q      <= slrg_pkg::RATE_RESET;
			out_valid_q <= 1'b0;
			flag_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				rate_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall && (state_q != slrg_pkg::S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				slrg_pkg::S_IDLE: begin
					if (in_acc) begin
						case (slrg_pkg::op_t'(operation))
							slrg_pkg::OP_START: begin
								if (tgt != goal_q) begin
									flag_q   <= !active_q;
									goal_q   <= tgt;
									origin_q <= cur_q;
									div_q    <= tick_divider;
									tick_q   <= '0;
									acc_q    <= '0;
									active_q <= 1'b1;
									state_q  <= slrg_pkg::S_PREP;
								end else begin
									flag_q  <= 1'b0;
									state_q <= slrg_pkg::S_FIN;
								end
							end
							slrg_pkg::OP_TICK: begin
								if (active_q) begin
									if (tick_nx < div_q) begin
										tick_q  <= tick_nx;
										flag_q  <= 1'b1;
										state_q <= slrg_pkg::S_FIN;
									end else begin
										tick_q  <= '0;
										acc_q   <= acc_d;
										flag_q  <= 1'b0;
										state_q <= slrg_pkg::S_TLVL;
									end
								end else begin
									flag_q  <= 1'b0;
									state_q <= slrg_pkg::S_FIN;
								end
							end
							slrg_pkg::OP_SNAP: begin
								cur_q    <= goal_q;
								tick_q   <= '0;
								acc_q    <= '0;
								active_q <= 1'b0;
								flag_q   <= 1'b0;
								state_q  <= slrg_pkg::S_FIN;
							end
							default: begin
								flag_q  <= 1'b0;
								state_q <= slrg_pkg::S_FIN;
							end
						endcase
					end
				end
				slrg_pkg::S_PREP: begin
					state_q <= slrg_pkg::S_CALC;
				end
				slrg_pkg::S_CALC: begin
					if (md_done) begin
						inc_q   <= inc_d;
						state_q <= slrg_pkg::S_FIN;
					end
				end
				slrg_pkg::S_TLVL: begin
					if (going) begin
						cur_q  <= lvl;
						flag_q <= 1'b1;
					end else begin
						cur_q    <= goal_q;
						acc_q    <= '0;
						active_q <= 1'b0;
					end
					state_q <= slrg_pkg::S_FIN;
				end
				slrg_pkg::S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= slrg_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= slrg_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			diff_q <= diff_d;
			time_q <= ramp_time_ms;
		end
		if ((state_q == slrg_pkg::S_FIN) && out_free) begin
			level_q    <= lvl_out;
			out_flag_q <= flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign flag      = out_flag_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q != slrg_pkg::S_IDLE))
		else $error("block idle right after accepting an item");

	a_idle_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (acc_q == '0))
		else $error("accumulator not clear while ramp idle");

	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_q == '0) || (tick_q < div_q))
		else $error("tick count reached divider");

	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == slrg_pkg::S_CALC))
		else $error("increment finished outside of calculation");
`endif

endmodule
